// ----- hw/rtl/mdp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_pkg: shared types and constants for the modular dot product checker
// Request and result payloads, reducer handshake structs and widths.
// ----------------------------------------------------------------------------
package mdp_pkg;

  localparam int FIELD_W           = 32;  // width of one element field
  localparam int VAL_W             = 64;  // width of the values that get reduced
  localparam int MOD_W             = 31;  // modulus / residue width
  localparam int CNT_W             = $clog2(VAL_W);
  localparam int ELEMENT_WIDTH_DEF = 32;

  typedef struct packed {
    logic signed [FIELD_W-1:0] left_element;
    logic signed [FIELD_W-1:0] right_element;
    logic signed [VAL_W-1:0]   expected_value;
    logic                      last_element;
  } mdp_in_t;

  typedef struct packed {
    logic [MOD_W-1:0] residue;
    logic             matches_res;
  } mdp_out_t;

  // start a reduction of a signed value modulo a nonzero modulus
  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] val;
    logic [MOD_W-1:0]        modulus;
  } mdp_red_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;    // one-cycle pulse, result valid with it
    logic [MOD_W-1:0] result;
  } mdp_red_st_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mdp_reduce.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_reduce: serial signed modular reduction
// Shift-and-subtract over the magnitude, one bit per cycle, then a sign fixup
// (m - r for negative inputs) through the same subtractor.
// ----------------------------------------------------------------------------
module mdp_reduce (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mdp_pkg::mdp_red_req_t req,
  output mdp_pkg::mdp_red_st_t  st
);
  import mdp_pkg::*;

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_STEP = 2'd1;
  localparam logic [1:0] R_FIX  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [VAL_W-1:0] mag_r, mag_nxt;
  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic [MOD_W-1:0] mod_r, mod_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  logic [MOD_W:0]   op_a, op_b;
  logic [MOD_W+1:0] diff;

  // the one shared subtractor
  always_comb begin
    if (state_r == R_FIX) begin
      op_a = {1'b0, mod_r};
      op_b = {1'b0, rem_r};
    end else begin
      op_a = {rem_r, mag_r[VAL_W-1]};
      op_b = {1'b0, mod_r};
    end
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    mod_nxt   = mod_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      R_IDLE: begin
        if (req.start) begin
          neg_nxt   = req.val[VAL_W-1];
          mag_nxt   = req.val[VAL_W-1] ? (~req.val + 1'b1) : req.val;
          rem_nxt   = '0;
          mod_nxt   = req.modulus;
          cnt_nxt   = CNT_W'(VAL_W - 1);
          state_nxt = R_STEP;
        end
      end
      R_STEP: begin
        // 2r + bit stays below 2m, so one conditional subtract suffices
        rem_nxt = diff[MOD_W+1] ? op_a[MOD_W-1:0] : diff[MOD_W-1:0];
        mag_nxt = {mag_r[VAL_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = R_FIX;
        end
      end
      R_FIX: begin
        if (neg_r && (rem_r != '0)) begin
          rem_nxt = diff[MOD_W-1:0];
        end
        done_nxt  = 1'b1;
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    mod_r <= mod_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign st.busy   = (state_r != R_IDLE);
  assign st.done   = done_r;
  assign st.result = rem_r;

endmodule
`default_nettype wire

// ----- hw/rtl/modular_dot_product_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modular_dot_product_check: running dot product residue and claim check
// Accumulates element products modulo a configured modulus and checks the
// claimed dot product on the last element of each vector.
// ----------------------------------------------------------------------------
// One request carries an element pair; the block takes it, multiplies the
// pair, adds the running residue and reduces that sum with a serial reducer
// at one bit per cycle; a request that is not the last of its vector keeps
// the block busy until that sum is reduced. On the last element the claimed
// value goes through the same reducer afterwards, and the residue plus the
// match flag come out as one result held in an output register; the next
// request may be taken while that result waits. Each value takes 64 reduction
// steps. A modulus written as 0 acts as 1. Write the modulus only while the
// block is idle.
// ----------------------------------------------------------------------------
module modular_dot_product_check #(
  parameter int ELEMENT_WIDTH = mdp_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  mdp_pkg::mdp_in_t          in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output mdp_pkg::mdp_out_t         out_data,
  input  wire                       cfg_wr_en,
  input  wire [mdp_pkg::MOD_W-1:0]  cfg_wr_data
);
  import mdp_pkg::*;

  localparam int PROD_W = 2 * ELEMENT_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_WSUM = 3'd3;
  localparam logic [2:0] S_WEXP = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                      state_r, state_nxt;
  logic [MOD_W-1:0]                mod_r;
  logic [MOD_W-1:0]                running_r, running_nxt;
  logic [MOD_W-1:0]                acc_r, acc_nxt;
  logic                            match_r, match_nxt;
  logic signed [ELEMENT_WIDTH-1:0] a_r, b_r;
  logic signed [PROD_W-1:0]        prod_r;
  logic signed [VAL_W-1:0]         exp_r;
  logic                            last_r;
  logic                            out_valid_r, out_valid_nxt;
  mdp_out_t                        out_r, out_nxt;

  logic                            in_take;
  logic                            out_take;
  logic signed [VAL_W-1:0]         prod_ext;
  mdp_red_req_t                    red_req;
  mdp_red_st_t                     red_st;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign prod_ext = VAL_W'(prod_r);

  mdp_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (red_req),
    .st    (red_st)
  );

  always_comb begin
    state_nxt     = state_r;
    running_nxt   = running_r;
    acc_nxt       = acc_r;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r && !out_take;
    out_nxt       = out_r;
    red_req.start   = 1'b0;
    red_req.val     = prod_ext + VAL_W'(running_r);
    red_req.modulus = mod_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        // running + product reduces to the same residue as the two separately
        red_req.start = 1'b1;
        state_nxt     = S_WSUM;
      end
      S_WSUM: begin
        if (red_st.done) begin
          acc_nxt = red_st.result;
          if (last_r) begin
            running_nxt   = '0;
            red_req.start = 1'b1;
            red_req.val   = exp_r;
            state_nxt     = S_WEXP;
          end else begin
            running_nxt = red_st.result;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_WEXP: begin
        if (red_st.done) begin
          match_nxt = (red_st.result == acc_r);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_take) begin
          out_nxt.residue     = acc_r;
          out_nxt.matches_res = match_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= MOD_W'(1);
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mod_r <= (cfg_wr_data == '0) ? MOD_W'(1) : cfg_wr_data;
      end
    end
    acc_r   <= acc_nxt;
    match_r <= match_nxt;
    out_r   <= out_nxt;
    if (in_take) begin
      a_r    <= in_data.left_element[ELEMENT_WIDTH-1:0];
      b_r    <= in_data.right_element[ELEMENT_WIDTH-1:0];
      exp_r  <= in_data.expected_value;
      last_r <= in_data.last_element;
    end
    if (state_r == S_MUL) begin
      prod_r <= a_r * b_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // reducer results only land in the two wait states
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    red_st.done |-> (state_r == S_WSUM || state_r == S_WEXP))
    else $error("reducer done outside a wait state");

  // never restart the reducer mid-run
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    red_req.start |-> !red_st.busy)
    else $error("reducer started while busy");

  // a new result is only loaded from the output state
  a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside output state");

  // request side stays blocked while a vector end is being checked
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WEXP) |=> in_stall)
    else $error("request accepted during claim check");

endmodule
`default_nettype wire
